// ===== rtl/prwc_pkg.sv =====
// prwc_pkg: widths, constants, shared types and the digit-step divide helper
// for the pulse rate window counter. Depends on nothing.
`default_nettype none

package prwc_pkg;

    localparam int TIME_W    = 32;
    localparam int SEC_W     = 26;                  // 2^32 / 125 needs 26 bits
    localparam int COUNT_W   = 8;
    localparam int TOTAL_W   = 11;
    localparam int DIGIT_W   = 4;                   // quotient bits produced per step
    localparam int DIV_STEPS = TIME_W / DIGIT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = 7;                   // holds 125 and any bin count up to 127
    localparam int NUM_W     = REM_W + DIGIT_W;

    localparam logic [REM_W-1:0]   TICKS_PER_SEC = 7'd125;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 11'h7FF;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [REM_W-1:0]   rem;
    } div_step_t;

    typedef struct packed {
        logic              update;
        logic [TIME_W-1:0] now;
        logic [SEC_W-1:0]  sec;
    } cell_cmd_t;

    // One radix-16 long-division step; num must stay below 16 * divisor.
    function automatic div_step_t div_step(input logic [NUM_W-1:0] num,
                                           input logic [REM_W-1:0] divisor);
        div_step_t        res;
        logic [NUM_W-1:0] mult;
        res.digit = '0;
        res.rem   = num[REM_W-1:0];
        mult      = '0;
        for (int k = 1; k < (1 << DIGIT_W); k++)
        begin
            mult = NUM_W'(k) * NUM_W'(divisor);
            if (num >= mult)
            begin
                res.digit = DIGIT_W'(k);
                res.rem   = REM_W'(num - mult);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/prwc_if.sv =====
// prwc_tick_if and prwc_rate_if: valid/ready channels of the pulse rate counter.
// Depends on prwc_pkg.
`default_nettype none

interface prwc_tick_if;
    import prwc_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ticks;
    logic              pulse_seen;

    modport source (output valid, output now_ticks, output pulse_seen, input ready);
    modport sink   (input valid, input now_ticks, input pulse_seen, output ready);
endinterface

interface prwc_rate_if;
    import prwc_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] pulse_total;
    logic               held;

    modport source (output valid, output pulse_total, output held, input ready);
    modport sink   (input valid, input pulse_total, input held, output ready);
endinterface

`default_nettype wire

// ===== rtl/prwc_divider.sv =====
// prwc_divider: digit-serial divide of the tick time by 125, with the second
// index reduced modulo the bin count on the fly. Depends on prwc_pkg.
`default_nettype none

module prwc_divider #(
    parameter int WINDOW_BINS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [prwc_pkg::TIME_W-1:0]  now,
    output logic                         done,
    output logic [prwc_pkg::SEC_W-1:0]   sec,
    output logic [((WINDOW_BINS > 1) ? $clog2(WINDOW_BINS) : 1)-1:0] slot
);
    import prwc_pkg::*;

    localparam int SLOT_W = (WINDOW_BINS > 1) ? $clog2(WINDOW_BINS) : 1;
    localparam logic [REM_W-1:0] BINS_DIV = REM_W'(WINDOW_BINS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_W-1:0]    num_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     mod_reg;
    logic [SEC_W-1:0]     sec_reg;

    div_step_t sec_step;
    div_step_t mod_step;

    // Quotient digit of now/125, then fold it into (now/125) mod WINDOW_BINS.
    always_comb
    begin
        sec_step = div_step({rem_reg, num_reg[TIME_W-1 -: DIGIT_W]}, TICKS_PER_SEC);
        mod_step = div_step({mod_reg, sec_step.digit}, BINS_DIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            mod_reg  <= '0;
            sec_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= now;
                rem_reg  <= '0;
                mod_reg  <= '0;
                sec_reg  <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[TIME_W-DIGIT_W-1:0], DIGIT_W'(0)};
                rem_reg <= sec_step.rem;
                mod_reg <= mod_step.rem;
                sec_reg <= {sec_reg[SEC_W-DIGIT_W-1:0], sec_step.digit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign sec  = sec_reg;
    assign slot = mod_reg[SLOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/prwc_cell.sv =====
// prwc_cell: one one-second bin (stamp, second index, count) plus its stage of
// the running-sum chain. Depends on prwc_pkg.
`default_nettype none

module prwc_cell #(
    parameter int WINDOW_BINS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prwc_pkg::cell_cmd_t           cmd,
    input  logic                          hit,
    input  logic [prwc_pkg::TOTAL_W-1:0]  sum_in,
    output logic [prwc_pkg::TOTAL_W-1:0]  sum_out
);
    import prwc_pkg::*;

    // Age in whole seconds exceeds the window once the raw gap reaches this.
    localparam logic [TIME_W-1:0] AGE_LIMIT =
        TIME_W'((WINDOW_BINS + 1) * int'(TICKS_PER_SEC));

    logic [TIME_W-1:0]  stamp_reg, stamp_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next;

    logic               restart;
    logic               aged;
    logic [TIME_W-1:0]  gap;
    logic [TOTAL_W:0]   sum_wide;

    always_comb
    begin
        restart    = hit && (sec_reg != cmd.sec);
        gap        = cmd.now - stamp_reg;
        aged       = !restart && (gap >= AGE_LIMIT);
        stamp_next = stamp_reg;
        sec_next   = sec_reg;
        count_next = count_reg;
        if (cmd.update)
        begin
            if (aged)
            begin
                stamp_next = '0;
                sec_next   = '0;
                count_next = '0;
            end
            else if (restart)
            begin
                stamp_next = cmd.now;
                sec_next   = cmd.sec;
                count_next = COUNT_W'(1);
            end
            else if (hit && (count_reg != COUNT_MAX))
            begin
                count_next = count_reg + 1'b1;
            end
        end

        // Only stamped bins count; saturate the running sum.
        sum_wide = {1'b0, sum_in};
        if (stamp_reg != '0)
        begin
            sum_wide = sum_wide + (TOTAL_W + 1)'(count_reg);
        end
        sum_next = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= '0;
            sec_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            stamp_reg <= stamp_next;
            sec_reg   <= sec_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/pulse_rate_window_counter_core.sv =====
// pulse_rate_window_counter_core: heartbeat pulse count over a sliding window of
// one-second bins. Depends on prwc_pkg, prwc_if, prwc_divider, prwc_cell.
//
//   channel | dir | payload                     | meaning
//   --------+-----+-----------------------------+-----------------------------------
//   tick    | in  | now_ticks[31:0], pulse_seen | time in 8 ms units, new pulse flag
//   rate    | out | pulse_total[10:0], held     | live window total, repeat flag
//
// A tick that comes within one time unit of the last counted tick is answered
// in the next cycle with the previous total. Any other tick passes through the
// digit-serial divide by 125 and its hand-off, then the bin update, and then
// the settling of the partial sum as it travels down the row of bin cells.
// Reset clears every bin at once. A new request is taken only when the block
// is idle and the result register is empty or being read in the same cycle.
`default_nettype none

module pulse_rate_window_counter_core #(
    parameter int WINDOW_BINS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    prwc_tick_if.sink   tick,
    prwc_rate_if.source rate
);
    import prwc_pkg::*;

    localparam int SLOT_W = (WINDOW_BINS > 1) ? $clog2(WINDOW_BINS) : 1;
    localparam int SUMC_W = $clog2(WINDOW_BINS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_SUM
    } state_t;

    state_t             state_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [TOTAL_W-1:0] held_total_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               pulse_reg;
    logic [SUMC_W-1:0]  sum_cnt_reg;
    logic               out_valid_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               out_held_reg;

    logic               tick_acc;
    logic [TIME_W-1:0]  gap;
    logic               too_soon;
    logic               div_start;
    logic               div_done;
    logic [SEC_W-1:0]   div_sec;
    logic [SLOT_W-1:0]  div_slot;
    cell_cmd_t          cmd;
    logic [WINDOW_BINS-1:0] hit;
    logic [TOTAL_W-1:0] sum_link [WINDOW_BINS+1];

    // Take a request only when idle and the result slot frees up.
    assign tick.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rate.ready);
    assign tick_acc   = tick.valid && tick.ready;

    // A gap of zero or one unit (modulo 2^32) holds the previous total.
    assign gap       = tick.now_ticks - last_time_reg;
    assign too_soon  = (gap[TIME_W-1:1] == '0);
    assign div_start = tick_acc && !too_soon;

    prwc_divider #(
        .WINDOW_BINS (WINDOW_BINS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .now   (tick.now_ticks),
        .done  (div_done),
        .sec   (div_sec),
        .slot  (div_slot)
    );

    // Broadcast the update to every cell; only the selected bin sees the pulse.
    assign cmd.update = (state_reg == ST_UPD);
    assign cmd.now    = now_reg;
    assign cmd.sec    = div_sec;

    assign sum_link[0] = '0;

    for (genvar i = 0; i < WINDOW_BINS; i++)
    begin : g_cell
        assign hit[i] = pulse_reg && (div_slot == SLOT_W'(i));

        prwc_cell #(
            .WINDOW_BINS (WINDOW_BINS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .hit     (hit[i]),
            .sum_in  (sum_link[i]),
            .sum_out (sum_link[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_time_reg  <= '0;
            held_total_reg <= '0;
            now_reg        <= '0;
            pulse_reg      <= 1'b0;
            sum_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_total_reg  <= '0;
            out_held_reg   <= 1'b0;
        end
        else
        begin
            // Drop the result once the sink takes it; a new result below wins.
            if (rate.valid && rate.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (div_start)
                    begin
                        now_reg       <= tick.now_ticks;
                        pulse_reg     <= tick.pulse_seen;
                        last_time_reg <= tick.now_ticks;
                        state_reg     <= ST_DIV;
                    end
                    else if (tick_acc)
                    begin
                        out_valid_reg <= 1'b1;
                        out_total_reg <= held_total_reg;
                        out_held_reg  <= 1'b1;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    // Cells apply the update at this edge; then let the sum settle.
                    sum_cnt_reg <= SUMC_W'(WINDOW_BINS);
                    state_reg   <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (sum_cnt_reg == '0)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_total_reg  <= sum_link[WINDOW_BINS];
                        out_held_reg   <= 1'b0;
                        held_total_reg <= sum_link[WINDOW_BINS];
                        state_reg      <= ST_IDLE;
                    end
                    else
                    begin
                        sum_cnt_reg <= sum_cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rate.valid       = out_valid_reg;
    assign rate.pulse_total = out_total_reg;
    assign rate.held        = out_held_reg;

endmodule

`default_nettype wire

// ===== rtl/prwc_checker.sv =====
// prwc_checker: port-level assertions for the pulse rate window counter, bound
// to the top level. Depends on prwc_pkg and pulse_rate_window_counter_core.
`default_nettype none

module prwc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [prwc_pkg::TIME_W-1:0]   in_now,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [prwc_pkg::TOTAL_W-1:0]  out_total,
    input logic                          out_held
);
    import prwc_pkg::*;

    logic               seen_reg;
    logic [TIME_W-1:0]  prev_now_reg;
    logic [TOTAL_W-1:0] last_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_now_reg   <= '0;
            last_total_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                seen_reg     <= 1'b1;
                prev_now_reg <= in_now;
            end
            if (out_valid && out_ready)
            begin
                last_total_reg <= out_total;
            end
        end
    end

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_total) && $stable(out_held))
        else $error("stalled result changed");

    // A repeated total equals the last total delivered.
    a_held_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_held |-> out_total == last_total_reg)
        else $error("held total differs from previous total");

    // A request with the same time as the previous one is answered at once, held.
    a_same_time_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && seen_reg && (in_now == prev_now_reg)
        |=> out_valid && out_held)
        else $error("same-time request not held");

endmodule

bind pulse_rate_window_counter_core prwc_checker u_prwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .in_now    (tick.now_ticks),
    .out_valid (rate.valid),
    .out_ready (rate.ready),
    .out_total (rate.pulse_total),
    .out_held  (rate.held)
);

`default_nettype wire
